[design/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse: cofactor operand indexes and the front-end stage count.
// ----------------------------------------------------------------------------
package m3i_pkg;

    // adjugate entry k = m[COF_IDX[k][0]] * m[COF_IDX[k][1]]
    //                  - m[COF_IDX[k][2]] * m[COF_IDX[k][3]]
    localparam logic [3:0] COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // register stages in the cofactor / determinant front end
    localparam int FRONT_LAT = 6;

endpackage

[design/m3i_if.sv]
// ----------------------------------------------------------------------------
// m3i_if
// Valid/ready channels carrying one input matrix and one inverse matrix with its singular flag.
// ----------------------------------------------------------------------------
interface m3i_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_r0c0;
    logic signed [W-1:0] in_r0c1;
    logic signed [W-1:0] in_r0c2;
    logic signed [W-1:0] in_r1c0;
    logic signed [W-1:0] in_r1c1;
    logic signed [W-1:0] in_r1c2;
    logic signed [W-1:0] in_r2c0;
    logic signed [W-1:0] in_r2c1;
    logic signed [W-1:0] in_r2c2;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        output ready
    );
endinterface

interface m3i_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_r0c0;
    logic signed [W-1:0] out_r0c1;
    logic signed [W-1:0] out_r0c2;
    logic signed [W-1:0] out_r1c0;
    logic signed [W-1:0] out_r1c1;
    logic signed [W-1:0] out_r1c2;
    logic signed [W-1:0] out_r2c0;
    logic signed [W-1:0] out_r2c1;
    logic signed [W-1:0] out_r2c2;
    logic                singular;

    modport source (
        output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
               out_r2c0, out_r2c1, out_r2c2, singular,
        input  ready
    );
    modport sink (
        input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
               out_r2c0, out_r2c1, out_r2c2, singular,
        output ready
    );
endinterface

[design/matrix3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a signed fixed-point 3x3 matrix via the exact adjugate and
// determinant, nine divider lanes and a merging output register.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready sink, one row-major matrix per item, ELEM_WIDTH-bit
//           signed elements with FRAC_BITS fraction bits.
//   o_out : valid/ready source, nine inverse elements (rounded to nearest,
//           ties away from zero, saturated) plus the singular flag.
//   A zero determinant returns the identity matrix with singular set.
//   Throughput: one item per cycle while o_out is not stalled.
//   Pipeline: six front stages (cofactor products, adjugate, split det
//   products, term recombination, det sum, magnitude), ELEM_WIDTH + 4 divider
//   stages that resolve one quotient bit per step, and the output register.
//   Stall: while o_out.valid is high and o_out.ready low, the whole pipeline
//   holds and i_in.ready is low; empty output lets a new item enter.
//   Reset: synchronous, active low; clears all valid bits, nothing in flight.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    m3i_in_if.sink    i_in,
    m3i_out_if.source o_out
);
    localparam int W    = ELEM_WIDTH;
    localparam int LLAT = W + 4;
    localparam int LAT  = m3i_pkg::FRONT_LAT + LLAT;
    localparam logic [W-1:0] ONE = (FRAC_BITS >= W - 1) ?
        W'((64'd1 << (W - 1)) - 64'd1) : W'(64'd1 << FRAC_BITS);

    logic                en;
    logic signed [W-1:0] m     [9];
    logic signed [2*W:0] adj   [9];
    logic [3*W+3:0]      dmag;
    logic                dneg;
    logic                dzero;
    logic [W-1:0]        q     [9];

    logic [LAT-1:0]      r_vld;
    logic [LLAT-1:0]     r_sng;
    logic                r_ovld;
    logic [W-1:0]        r_o   [9];
    logic                r_osng;

    assign en = !r_ovld || o_out.ready;
    assign i_in.ready = en;

    assign m[0] = i_in.in_r0c0;
    assign m[1] = i_in.in_r0c1;
    assign m[2] = i_in.in_r0c2;
    assign m[3] = i_in.in_r1c0;
    assign m[4] = i_in.in_r1c1;
    assign m[5] = i_in.in_r1c2;
    assign m[6] = i_in.in_r2c0;
    assign m[7] = i_in.in_r2c1;
    assign m[8] = i_in.in_r2c2;

    m3i_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_m     (m),
        .o_adj   (adj),
        .o_dmag  (dmag),
        .o_dneg  (dneg),
        .o_dzero (dzero)
    );

    for (genvar k = 0; k < 9; k++) begin : g_lane
        m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_adj  (adj[k]),
            .i_dmag (dmag),
            .i_dneg (dneg),
            .o_q    (q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[LAT-2:0], i_in.valid};
            r_ovld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sng  <= {r_sng[LLAT-2:0], dzero};
            r_osng <= r_sng[LLAT-1];
            for (int k = 0; k < 9; k++) begin
                if (r_sng[LLAT-1]) begin
                    r_o[k] <= (k % 4 == 0) ? ONE : '0;
                end else begin
                    r_o[k] <= q[k];
                end
            end
        end
    end

    assign o_out.valid    = r_ovld;
    assign o_out.singular = r_osng;
    assign o_out.out_r0c0 = r_o[0];
    assign o_out.out_r0c1 = r_o[1];
    assign o_out.out_r0c2 = r_o[2];
    assign o_out.out_r1c0 = r_o[3];
    assign o_out.out_r1c1 = r_o[4];
    assign o_out.out_r1c2 = r_o[5];
    assign o_out.out_r2c0 = r_o[6];
    assign o_out.out_r2c1 = r_o[7];
    assign o_out.out_r2c2 = r_o[8];

endmodule

[design/m3i_front.sv]
// ----------------------------------------------------------------------------
// m3i_front
// Exact adjugate and determinant, six register stages, no multiplier
// wider than W x (W+1).
// ----------------------------------------------------------------------------
module m3i_front #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_m    [9],
    output logic signed [2*W:0]   o_adj  [9],
    output logic [3*W+3:0]        o_dmag,
    output logic                  o_dneg,
    output logic                  o_dzero
);
    localparam int CW = 2 * W + 1;
    localparam int TW = 3 * W + 2;
    localparam int DW = 3 * W + 4;

    logic signed [2*W-1:0] r_p1   [9];
    logic signed [2*W-1:0] r_p2   [9];
    logic signed [W-1:0]   r_m1   [3];
    logic signed [W-1:0]   r_m2   [3];
    logic signed [CW-1:0]  r_adj2 [9];
    logic signed [CW-1:0]  r_adj3 [9];
    logic signed [CW-1:0]  r_adj4 [9];
    logic signed [CW-1:0]  r_adj5 [9];
    logic signed [CW-1:0]  r_adj6 [9];
    logic signed [2*W:0]   r_plo  [3];
    logic signed [2*W:0]   r_phi  [3];
    logic signed [TW-1:0]  r_term [3];
    logic signed [DW-1:0]  r_det;
    logic [DW-1:0]         r_dmag;
    logic                  r_dneg;
    logic                  r_dzero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p1[k] <= i_m[m3i_pkg::COF_IDX[k][0]] * i_m[m3i_pkg::COF_IDX[k][1]];
                r_p2[k] <= i_m[m3i_pkg::COF_IDX[k][2]] * i_m[m3i_pkg::COF_IDX[k][3]];
                r_adj2[k] <= CW'(r_p1[k]) - CW'(r_p2[k]);
                r_adj3[k] <= r_adj2[k];
                r_adj4[k] <= r_adj3[k];
                r_adj5[k] <= r_adj4[k];
                r_adj6[k] <= r_adj5[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_m1[j]  <= i_m[j];
                r_m2[j]  <= r_m1[j];
                // split cofactor: unsigned low W bits, signed high W+1 bits
                r_plo[j] <= r_m2[j] * $signed({1'b0, r_adj2[3*j][W-1:0]});
                r_phi[j] <= r_m2[j] * $signed(r_adj2[3*j][CW-1:W]);
                r_term[j] <= (TW'(r_phi[j]) <<< W) + TW'(r_plo[j]);
            end
            r_det   <= DW'(r_term[0]) + DW'(r_term[1]) + DW'(r_term[2]);
            r_dmag  <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_dneg  <= r_det[DW-1];
            r_dzero <= (r_det == '0);
        end
    end

    assign o_adj   = r_adj6;
    assign o_dmag  = r_dmag;
    assign o_dneg  = r_dneg;
    assign o_dzero = r_dzero;

endmodule

[design/m3i_div_lane.sv]
// ----------------------------------------------------------------------------
// m3i_div_lane
// One divider lane: round(adj * 2^(2F) / det), saturated, one quotient bit
// per divide step. W+4 register stages.
// ----------------------------------------------------------------------------
module m3i_div_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [2*W:0]  i_adj,
    input  logic [3*W+3:0]       i_dmag,
    input  logic                 i_dneg,
    output logic [W-1:0]         o_q
);
    localparam int CW = 2 * W + 1;
    localparam int NW = CW + 2 * F;
    localparam int DW = 3 * W + 4;
    localparam int QB = W + 1;
    localparam int XW = NW + DW;

    logic [NW-1:0] r_na;
    logic [DW-1:0] r_da;
    logic          r_nega;

    logic [DW-1:0] r_rem  [QB+1];
    logic [QB-1:0] r_low  [QB+1];
    logic [QB-1:0] r_quo  [QB+1];
    logic [DW-1:0] r_d    [QB+1];
    logic          r_neg  [QB+1];
    logic          r_sat  [QB+1];

    logic [QB:0]   r_v;
    logic          r_satr;
    logic          r_negr;

    logic [CW-1:0] amag;
    logic [DW:0]   twice;
    logic [QB:0]   lim;
    logic [QB:0]   vc;
    logic [QB:0]   vp;

    assign amag = i_adj[CW-1] ? CW'(-i_adj) : CW'(i_adj);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na   <= NW'(amag) << (2 * F);
            r_da   <= i_dmag;
            r_nega <= i_adj[CW-1] ^ i_dneg;

            r_sat[0] <= (XW'(r_na) >> QB) >= XW'(r_da);
            r_rem[0] <= DW'(r_na >> QB);
            r_low[0] <= r_na[QB-1:0];
            r_quo[0] <= '0;
            r_d[0]   <= r_da;
            r_neg[0] <= r_nega;
        end
    end

    for (genvar i = 0; i < QB; i++) begin : g_step
        logic [DW:0] t;
        logic        ge;
        assign t  = {r_rem[i], r_low[i][QB-1]};
        assign ge = t >= {1'b0, r_d[i]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= ge ? DW'(t - {1'b0, r_d[i]}) : DW'(t);
                r_low[i+1] <= r_low[i] << 1;
                r_quo[i+1] <= {r_quo[i][QB-2:0], ge};
                r_d[i+1]   <= r_d[i];
                r_neg[i+1] <= r_neg[i];
                r_sat[i+1] <= r_sat[i];
            end
        end
    end

    // round half away from zero on the magnitude
    assign twice = {r_rem[QB], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= (QB+1)'(r_quo[QB]) + (QB+1)'(twice >= {1'b0, r_d[QB]});
            r_satr <= r_sat[QB];
            r_negr <= r_neg[QB];
        end
    end

    assign lim = (QB+1)'(1) << (W - 1);
    assign vc  = (r_satr || (r_v > lim)) ? lim : r_v;
    assign vp  = (vc > lim - 1'b1) ? lim - 1'b1 : vc;
    assign o_q = r_negr ? W'(-vc) : W'(vp);

endmodule

[design/m3i_checker.sv]
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks for matrix3_inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker #(
    parameter int W = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic         i_sng,
    input logic [W-1:0] i_e [9]
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_e[0]) && $stable(i_sng))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sng |-> i_e[4] == i_e[0] && i_e[8] == i_e[0] && i_e[0] != '0
            && i_e[1] == '0 && i_e[2] == '0 && i_e[3] == '0 && i_e[5] == '0
            && i_e[6] == '0 && i_e[7] == '0)
        else $error("singular item is not the identity");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind matrix3_inverse m3i_checker #(.W(ELEM_WIDTH)) u_m3i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sng       (o_out.singular),
    .i_e         ('{o_out.out_r0c0, o_out.out_r0c1, o_out.out_r0c2,
                    o_out.out_r1c0, o_out.out_r1c1, o_out.out_r1c2,
                    o_out.out_r2c0, o_out.out_r2c1, o_out.out_r2c2})
);
